/* hdl/ckts_pkg.sv */
// shared types and codes of the cubic keyframe track sampler
`default_nettype none
package ckts_pkg;

    // request kinds on the input channel
    localparam logic [1:0] KIND_KEY    = 2'd0;
    localparam logic [1:0] KIND_COEF   = 2'd1;
    localparam logic [1:0] KIND_SAMPLE = 2'd2;

    // channel codes
    localparam logic [1:0] CH_ROT   = 2'd0;
    localparam logic [1:0] CH_TRANS = 2'd1;
    localparam logic [1:0] CH_SCALE = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_ROT_COUNT   = 2'd0;
    localparam logic [1:0] REG_TRANS_COUNT = 2'd1;
    localparam logic [1:0] REG_SCALE_COUNT = 2'd2;

    // last component and last term codes
    localparam logic [1:0] COMP_W    = 2'd3;
    localparam logic [1:0] COMP_Z    = 2'd2;
    localparam logic [1:0] TERM_LAST = 2'd3;

    // controls of the shared multiply-add unit
    typedef struct packed {
        logic load;
        logic mul;
        logic add;
    } mac_ctl_t;

endpackage
`default_nettype wire

/* hdl/ckts_ram.sv */
// generic single-port-write ram with registered read
`default_nettype none
module ckts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 192
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

/* hdl/ckts_mac.sv */
// shared horner unit: registered multiply, then floor shift, add and saturate
`default_nettype none
module ckts_mac (
    input  wire logic                  aclk,
    input  wire ckts_pkg::mac_ctl_t    ctl,
    input  wire logic signed [31:0]    coef,
    input  wire logic signed [32:0]    d,
    output logic signed [31:0]         acc
);
    import ckts_pkg::*;

    logic signed [31:0] acc_reg, acc_next;
    logic signed [64:0] prod_reg;
    logic signed [49:0] sum;

    // floor of product over 2^16 plus coefficient
    assign sum = 50'(prod_reg >>> 16) + 50'(coef);

    // saturate to signed 32 bits
    always_comb begin
        if (sum > 50'sd2147483647) begin
            acc_next = 32'sh7fffffff;
        end else if (sum < -50'sd2147483648) begin
            acc_next = 32'sh80000000;
        end else begin
            acc_next = 32'(sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            acc_reg <= coef;
        end else if (ctl.add) begin
            acc_reg <= acc_next;
        end
        if (ctl.mul) begin
            prod_reg <= 65'(acc_reg) * 65'(d);
        end
    end

    assign acc = acc_reg;
endmodule
`default_nettype wire

/* hdl/cubic_keyframe_track_sampler.sv */
// top level of the cubic keyframe track sampler
//
// Input requests arrive on s_tvalid/s_tready with the kind in s_tuser.
// Key time and coefficient loads are written in the cycle they are accepted
// and give no result. A sample request gives three results on m_*: rotation,
// translation and scale, in that order, the channel code in m_tuser and
// m_tlast high on the scale result.
// Per channel the key time memory is read once per key scanned, through its
// single read port, then each component takes a coefficient read, a load,
// three multiply/add pairs on the one shared multiply-add unit and a store,
// and the result is then shown on m_* until it is taken.
// The block takes one request at a time; s_tready is high only while idle.
// A stalled receiver holds a result on m_tdata until m_tready; the block
// waits meanwhile. Reset clears the sequencer and sets every key count to
// one; the key and coefficient memories hold garbage until written and need
// no clearing pass.
`default_nettype none
module cubic_keyframe_track_sampler #(
    parameter int MAX_KEYS = 64
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // channel, key_index, component, key_start, coef_cubed, coef_squared,
    // coef_linear, coef_constant, sample_time, zero pad
    input  wire logic [207:0] s_tdata,
    // kind
    input  wire logic [1:0]   s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // value_x, value_y, value_z, value_w
    output logic [127:0]      m_tdata,
    // out_channel
    output logic [1:0]        m_tuser,
    output logic              m_tlast,
    input  wire logic         cfg_we,
    input  wire logic [1:0]   cfg_addr,
    input  wire logic [6:0]   cfg_wdata
);
    import ckts_pkg::*;

    localparam int KT_DEPTH = 3 * MAX_KEYS;
    localparam int KT_AW    = $clog2(KT_DEPTH);
    localparam int CF_DEPTH = 4 * KT_DEPTH;
    localparam int CF_AW    = KT_AW + 2;
    localparam int KIW      = $clog2(MAX_KEYS);
    localparam int KW       = $clog2(MAX_KEYS + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_KT_RD, ST_KT_CMP, ST_CF_RD, ST_LOAD, ST_MUL, ST_ADD,
        ST_STORE, ST_OUT
    } state_t;

    // input fields
    logic [1:0]  in_channel, in_component;
    logic [5:0]  in_key;
    logic [31:0] in_key_start, in_sample_time;
    logic [127:0] in_coefs;
    assign in_channel     = s_tdata[1:0];
    assign in_key         = s_tdata[7:2];
    assign in_component   = s_tdata[9:8];
    assign in_key_start   = s_tdata[41:10];
    assign in_coefs       = s_tdata[169:42];
    assign in_sample_time = s_tdata[201:170];

    state_t             state_reg;
    logic [6:0]         count_reg [3];
    logic [1:0]         ch_reg, comp_reg, term_reg;
    logic [KW-1:0]      idx_reg;
    logic [KIW-1:0]     key_reg;
    logic [31:0]        t_reg, prev_reg;
    logic signed [32:0] d_reg;
    logic [31:0]        val_reg [4];

    // key count in use on the current channel
    logic [31:0] cnt32, n32;
    logic [KW-1:0] n_keys;
    assign cnt32 = {25'd0, count_reg[ch_reg]};
    always_comb begin
        if (cnt32 == 32'd0) begin
            n32 = 32'd1;
        end else if (cnt32 > 32'(MAX_KEYS)) begin
            n32 = 32'(MAX_KEYS);
        end else begin
            n32 = cnt32;
        end
    end
    assign n_keys = KW'(n32);

    // load decode
    logic in_acc, key_ok, kt_we, cf_we;
    assign in_acc = s_tvalid && s_tready;
    assign key_ok = ({26'd0, in_key} < 32'(MAX_KEYS)) && (in_channel <= CH_SCALE);
    assign kt_we  = in_acc && (s_tuser == KIND_KEY) && key_ok;
    assign cf_we  = in_acc && (s_tuser == KIND_COEF) && key_ok
                    && !((in_channel != CH_ROT) && (in_component == COMP_W));

    logic [KT_AW-1:0] wr_row, kt_raddr, key_row;
    logic [CF_AW-1:0] cf_raddr;
    assign wr_row   = KT_AW'(in_channel) * KT_AW'(MAX_KEYS) + KT_AW'(in_key);
    assign kt_raddr = KT_AW'(ch_reg) * KT_AW'(MAX_KEYS) + KT_AW'(idx_reg[KIW-1:0]);
    assign key_row  = KT_AW'(ch_reg) * KT_AW'(MAX_KEYS) + KT_AW'(key_reg);
    assign cf_raddr = {key_row, comp_reg};

    logic [31:0]  kt_rdata;
    logic [127:0] cf_rdata;

    ckts_ram #(.WIDTH(32), .DEPTH(KT_DEPTH)) u_kt_ram (
        .aclk(aclk), .we(kt_we), .waddr(wr_row), .wdata(in_key_start),
        .raddr(kt_raddr), .rdata(kt_rdata)
    );

    ckts_ram #(.WIDTH(128), .DEPTH(CF_DEPTH)) u_cf_ram (
        .aclk(aclk), .we(cf_we), .waddr({wr_row, in_component}), .wdata(in_coefs),
        .raddr(cf_raddr), .rdata(cf_rdata)
    );

    // shared multiply-add unit
    mac_ctl_t           mac_ctl;
    logic signed [31:0] mac_coef, acc;
    assign mac_ctl.load = (state_reg == ST_LOAD);
    assign mac_ctl.mul  = (state_reg == ST_MUL);
    assign mac_ctl.add  = (state_reg == ST_ADD);
    always_comb begin
        case (term_reg)
            2'd0:    mac_coef = cf_rdata[31:0];
            2'd1:    mac_coef = cf_rdata[63:32];
            2'd2:    mac_coef = cf_rdata[95:64];
            default: mac_coef = cf_rdata[127:96];
        endcase
    end

    ckts_mac u_mac (
        .aclk(aclk), .ctl(mac_ctl), .coef(mac_coef), .d(d_reg), .acc(acc)
    );

    logic last_comp;
    assign last_comp = (comp_reg == COMP_W) || ((comp_reg == COMP_Z) && (ch_reg != CH_ROT));

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg[0] <= 7'd1;
            count_reg[1] <= 7'd1;
            count_reg[2] <= 7'd1;
            ch_reg       <= CH_ROT;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    REG_ROT_COUNT:   count_reg[0] <= cfg_wdata;
                    REG_TRANS_COUNT: count_reg[1] <= cfg_wdata;
                    REG_SCALE_COUNT: count_reg[2] <= cfg_wdata;
                    default: ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (in_acc && (s_tuser == KIND_SAMPLE)) begin
                        t_reg     <= in_sample_time;
                        ch_reg    <= CH_ROT;
                        idx_reg   <= '0;
                        state_reg <= ST_KT_RD;
                    end
                end
                ST_KT_RD: state_reg <= ST_KT_CMP;
                ST_KT_CMP: begin
                    if (kt_rdata > t_reg) begin
                        if (idx_reg == '0) begin
                            key_reg <= '0;
                            d_reg   <= $signed({1'b0, t_reg}) - $signed({1'b0, kt_rdata});
                        end else begin
                            key_reg <= KIW'(idx_reg - KW'(1));
                            d_reg   <= $signed({1'b0, t_reg}) - $signed({1'b0, prev_reg});
                        end
                        comp_reg  <= '0;
                        state_reg <= ST_CF_RD;
                    end else if (idx_reg + KW'(1) == n_keys) begin
                        key_reg   <= idx_reg[KIW-1:0];
                        d_reg     <= $signed({1'b0, t_reg}) - $signed({1'b0, kt_rdata});
                        comp_reg  <= '0;
                        state_reg <= ST_CF_RD;
                    end else begin
                        prev_reg  <= kt_rdata;
                        idx_reg   <= idx_reg + KW'(1);
                        state_reg <= ST_KT_RD;
                    end
                end
                ST_CF_RD: begin
                    term_reg  <= '0;
                    state_reg <= ST_LOAD;
                end
                ST_LOAD: begin
                    term_reg  <= 2'd1;
                    state_reg <= ST_MUL;
                end
                ST_MUL: state_reg <= ST_ADD;
                ST_ADD: begin
                    if (term_reg == TERM_LAST) begin
                        state_reg <= ST_STORE;
                    end else begin
                        term_reg  <= term_reg + 2'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_STORE: begin
                    val_reg[comp_reg] <= acc;
                    if (last_comp) begin
                        state_reg <= ST_OUT;
                    end else begin
                        comp_reg  <= comp_reg + 2'd1;
                        state_reg <= ST_CF_RD;
                    end
                end
                ST_OUT: begin
                    if (m_tready) begin
                        if (ch_reg == CH_SCALE) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            ch_reg    <= ch_reg + 2'd1;
                            idx_reg   <= '0;
                            state_reg <= ST_KT_RD;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tuser  = ch_reg;
    assign m_tlast  = (ch_reg == CH_SCALE);
    assign m_tdata  = {(ch_reg == CH_ROT) ? val_reg[3] : 32'd0,
                       val_reg[2], val_reg[1], val_reg[0]};
endmodule
`default_nettype wire

/* hdl/ckts_checker.sv */
// port-level checker of the sampler and its bind
`default_nettype none
module ckts_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic [1:0]   s_tuser,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [127:0] m_tdata,
    input wire logic [1:0]   m_tuser,
    input wire logic         m_tlast
);
    import ckts_pkg::*;

    // never takes a request while a result is shown
    a_busy_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready) else $error("request taken during output");

    // a sample request makes the block busy
    a_sample_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && (s_tuser == KIND_SAMPLE) |=> !s_tready)
        else $error("ready after sample request");

    // the last result is the scale one
    a_last_scale: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == CH_SCALE)
        else $error("last on wrong channel");

    // after the last result the block goes idle
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid && s_tready)
        else $error("not idle after run");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");
endmodule

bind cubic_keyframe_track_sampler ckts_checker u_ckts_checker (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .s_tuser(s_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
    .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tlast(m_tlast)
);
`default_nettype wire

/* sim/cubic_keyframe_track_sampler_tb.sv */
// self-checking testbench of the cubic keyframe track sampler
`default_nettype none
module cubic_keyframe_track_sampler_tb;
    import ckts_pkg::*;

    localparam int NKEYS      = 64;
    localparam int NFILL      = 4;
    localparam int IDLE_LIMIT = 5000;
    localparam int HOLD_LEN   = 400;

    typedef struct {
        logic [1:0]  kind;
        logic [1:0]  ch;
        logic [5:0]  key;
        logic [1:0]  comp;
        logic [31:0] kstart;
        logic [31:0] coef [4];
        logic [31:0] stime;
    } request_t;

    typedef struct {
        logic [1:0]  ch;
        logic [31:0] val [4];
        logic        last;
    } sample_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [207:0] s_tdata = '0;
    logic [1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [1:0] m_tuser;
    logic m_tlast;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_addr = '0;
    logic [6:0] cfg_wdata = '0;

    // mirror of the block state
    logic [31:0] key_time [3][NKEYS];
    logic [31:0] coef_mem [3][NKEYS][4][4];
    logic [6:0]  key_count [3];

    sample_t expected_samples [$];
    int fail_count = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int idle_cycles = 0;
    logic s_fire_next = 1'b0;
    logic m_fire_next = 1'b0;

    cubic_keyframe_track_sampler u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    // one cubic channel evaluated in horner form
    function automatic sample_t eval_channel(logic [1:0] ch, logic [31:0] t);
        sample_t r;
        int n;
        int k;
        longint d;
        longint acc;
        longint p;
        n = (key_count[ch] == 0) ? 1 : (key_count[ch] > NKEYS) ? NKEYS : int'(key_count[ch]);
        k = n - 1;
        for (int i = 0; i < n; i++) begin
            if (key_time[ch][i] > t) begin
                k = (i == 0) ? 0 : i - 1;
                break;
            end
        end
        d = longint'({32'd0, t}) - longint'({32'd0, key_time[ch][k]});
        r.ch = ch;
        r.last = (ch == CH_SCALE);
        for (int c = 0; c < 4; c++) begin
            acc = 0;
            if (ch == CH_ROT || c != 3) begin
                acc = longint'(signed'(coef_mem[ch][k][c][0]));
                for (int term = 1; term < 4; term++) begin
                    p = (acc * d) >>> 16;
                    acc = p + longint'(signed'(coef_mem[ch][k][c][term]));
                    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
                    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
                end
            end
            r.val[c] = acc[31:0];
        end
        return r;
    endfunction

    // apply an accepted request to the mirror
    function automatic void predict_request(request_t rq);
        if (rq.kind == KIND_SAMPLE) begin
            expected_samples.push_back(eval_channel(CH_ROT, rq.stime));
            expected_samples.push_back(eval_channel(CH_TRANS, rq.stime));
            expected_samples.push_back(eval_channel(CH_SCALE, rq.stime));
        end else if (rq.kind == KIND_KEY && rq.ch <= CH_SCALE) begin
            key_time[rq.ch][rq.key] = rq.kstart;
        end else if (rq.kind == KIND_COEF && rq.ch <= CH_SCALE
                     && !(rq.ch != CH_ROT && rq.comp == COMP_W)) begin
            for (int term = 0; term < 4; term++) coef_mem[rq.ch][rq.key][rq.comp][term] = rq.coef[term];
        end
    endfunction

    // send one request, with optional idle cycles first
    task automatic send_request(request_t rq);
        if (tx_idle_pct > 0) begin
            while ($urandom_range(99) < tx_idle_pct) begin
                s_tvalid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser <= rq.kind;
        s_tdata <= {6'd0, rq.stime, rq.coef[3], rq.coef[2], rq.coef[1], rq.coef[0],
                    rq.kstart, rq.comp, rq.key, rq.ch};
        forever begin
            @(negedge aclk);
            if (s_tready) begin
                predict_request(rq);
                @(posedge aclk);
                break;
            end
            @(posedge aclk);
        end
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coef();
        if ($urandom_range(1)) return $urandom;
        return 32'($urandom_range(32'h3FFFF)) - 32'h20000;
    endfunction

    function automatic request_t make_request(logic [1:0] kind, logic [1:0] ch, int key,
                                              logic [1:0] comp);
        request_t rq;
        rq.kind = kind;
        rq.ch = ch;
        rq.key = key[5:0];
        rq.comp = comp;
        rq.kstart = $urandom;
        for (int i = 0; i < 4; i++) rq.coef[i] = rand_coef();
        rq.stime = $urandom;
        return rq;
    endfunction

    task automatic sample_at(logic [31:0] t);
        request_t rq;
        rq = make_request(KIND_SAMPLE, 2'($urandom_range(3)), $urandom_range(63),
                          2'($urandom_range(3)));
        rq.stime = t;
        send_request(rq);
    endtask

    task automatic wait_drained();
        stop_sending();
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // key count write while idle
    task automatic write_key_count(logic [1:0] idx, logic [6:0] value);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        key_count[idx] = value;
        @(posedge aclk);
    endtask

    // fill the first keys of every channel; the random phases keep key counts within them
    task automatic test_fill_stores();
        request_t rq;
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < NFILL; k++) begin
                rq = make_request(KIND_KEY, ch[1:0], k, 2'd0);
                rq.kstart = 32'h100 + k * 32'h0004_0000 + $urandom_range(16'hFFFF);
                send_request(rq);
                for (int c = 0; c < 4; c++) begin
                    if (ch == CH_ROT || c != 3) send_request(make_request(KIND_COEF, ch[1:0], k, c[1:0]));
                end
            end
        end
    endtask

    // extremes of fields, ignored loads, out-of-range counts
    task automatic test_directed();
        request_t rq;
        write_key_count(REG_ROT_COUNT, 7'(NFILL));
        write_key_count(REG_TRANS_COUNT, 7'(NFILL));
        write_key_count(REG_SCALE_COUNT, 7'(NFILL));
        sample_at(32'h0);
        sample_at(32'hFFFF_FFFF);
        sample_at(key_time[CH_TRANS][2]);
        // saturating coefficients on rotation w and z
        rq = make_request(KIND_COEF, CH_ROT, 0, COMP_W);
        rq.coef = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        send_request(rq);
        rq.comp = COMP_Z;
        rq.coef = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF};
        send_request(rq);
        // key time at the top of the range on the last scale key in use, and zero on the first translation key
        rq = make_request(KIND_KEY, CH_SCALE, NFILL - 1, 2'd0);
        rq.kstart = 32'hFFFF_FFFF;
        send_request(rq);
        rq.ch = CH_TRANS;
        rq.key = 6'd0;
        rq.kstart = 32'h0;
        send_request(rq);
        sample_at(32'hFFFF_FFFF);
        sample_at(32'h0);
        // loads that must be dropped
        send_request(make_request(KIND_KEY, 2'd3, 5, 2'd0));
        send_request(make_request(KIND_COEF, 2'd3, 5, 2'd1));
        send_request(make_request(KIND_COEF, CH_TRANS, 5, COMP_W));
        send_request(make_request(KIND_COEF, CH_SCALE, 5, COMP_W));
        send_request(make_request(2'd3, CH_ROT, 5, 2'd0));
        sample_at(key_time[CH_SCALE][1] + 32'h10);
        // zero count and a count above the maximum; the search stops early
        write_key_count(REG_ROT_COUNT, 7'd0);
        write_key_count(REG_TRANS_COUNT, 7'd127);
        write_key_count(REG_SCALE_COUNT, 7'd1);
        sample_at(32'h0);
        sample_at(key_time[CH_TRANS][1] - 32'h1);
        sample_at(key_time[CH_TRANS][2]);
    endtask

    // one random phase
    task automatic test_random(int n_items, int tx_pct, int rx_pct);
        request_t rq;
        int sel;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        write_key_count(REG_ROT_COUNT, 7'($urandom_range(NFILL)));
        write_key_count(REG_TRANS_COUNT, 7'($urandom_range(NFILL)));
        write_key_count(REG_SCALE_COUNT, 7'($urandom_range(1, NFILL)));
        for (int i = 0; i < n_items; i++) begin
            sel = $urandom_range(99);
            if (sel < 45) begin
                rq = make_request(KIND_SAMPLE, 2'($urandom_range(3)), $urandom_range(63),
                                  2'($urandom_range(3)));
                if ($urandom_range(1))
                    rq.stime = key_time[$urandom_range(2)][$urandom_range(NFILL - 1)]
                               + $urandom_range(32'h8_0000) - 32'h1_0000;
            end else if (sel < 60) begin
                rq = make_request(KIND_KEY, 2'($urandom_range(3)), $urandom_range(63),
                                  2'($urandom_range(3)));
            end else if (sel < 90) begin
                rq = make_request(KIND_COEF, 2'($urandom_range(3)), $urandom_range(63),
                                  2'($urandom_range(3)));
            end else begin
                rq = make_request(2'd3, 2'($urandom_range(3)), $urandom_range(63),
                                  2'($urandom_range(3)));
            end
            send_request(rq);
        end
    endtask

    // long receiver hold while requests keep coming, then a full drain
    task automatic test_backpressure();
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_req++;
        for (int i = 0; i < 5; i++) sample_at($urandom);
        wait_drained();
        sample_at($urandom);
        wait_drained();
    endtask

    // receiver side ready
    always @(posedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_LEN;
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // result check, sampled away from the active edge
    always @(negedge aclk) begin
        sample_t want;
        s_fire_next <= s_tvalid && s_tready;
        m_fire_next <= m_tvalid && m_tready;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_samples.size() == 0) begin
                $error("result with nothing expected: channel %0d", m_tuser);
                fail_count++;
            end else begin
                want = expected_samples.pop_front();
                if (m_tuser !== want.ch) begin
                    $error("out_channel expected %0d got %0d", want.ch, m_tuser);
                    fail_count++;
                end
                if (m_tdata[31:0] !== want.val[0]) begin
                    $error("value_x expected %h got %h", want.val[0], m_tdata[31:0]);
                    fail_count++;
                end
                if (m_tdata[63:32] !== want.val[1]) begin
                    $error("value_y expected %h got %h", want.val[1], m_tdata[63:32]);
                    fail_count++;
                end
                if (m_tdata[95:64] !== want.val[2]) begin
                    $error("value_z expected %h got %h", want.val[2], m_tdata[95:64]);
                    fail_count++;
                end
                if (m_tdata[127:96] !== want.val[3]) begin
                    $error("value_w expected %h got %h", want.val[3], m_tdata[127:96]);
                    fail_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last expected %0d got %0d", want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    // watchdog on cycles without any request or result moving
    always @(posedge aclk) begin
        if (s_fire_next || m_fire_next || !aresetn) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        for (int i = 0; i < 3; i++) key_count[i] = 7'd1;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_fill_stores();
        test_directed();
        test_random(24, 0, 0);
        test_random(24, 78, 0);
        test_random(24, 0, 78);
        test_random(24, 31, 31);
        test_backpressure();
        wait_drained();
        repeat (50) @(posedge aclk);
        if (fail_count == 0 && expected_samples.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
